/* hdl/length_prefixed_record_fifo_macros.svh */
// Assertion macros for the length-prefixed record FIFO checker.
// Used by rlf_checker only; clocked on i_clk, reset i_rst_n active low.
`ifndef LENGTH_PREFIXED_RECORD_FIFO_MACROS_SVH
`define LENGTH_PREFIXED_RECORD_FIFO_MACROS_SVH

// property checked outside reset
`define RLF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("rlf assertion failed");

// property checked during reset too
`define RLF_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("rlf reset assertion failed");

`endif

/* hdl/rlf_pkg.sv */
// Shared types and constants for the length-prefixed record FIFO.
// No dependencies.
package rlf_pkg;

    localparam int STORE_DEPTH_DEF   = 1024;
    localparam int MAX_RECORD_BYTES  = 255;
    localparam logic [7:0] READ_LIMIT_RESET = 8'd255;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;
    localparam logic [1:0] ST_ERROR = 2'd3;

    typedef enum logic [1:0] {
        K_START,
        K_APPEND,
        K_READ,
        K_BAD
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] len;
        logic [7:0] data;
    } t_item;

endpackage

/* hdl/rlf_front.sv */
// Front end: classifies incoming commands and holds them in a two-entry queue.
// Depends on rlf_pkg.
module rlf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [1:0]     i_command,
    input  logic [7:0]     i_record_length,
    input  logic [7:0]     i_data_byte,
    input  logic           i_pop,
    output logic           o_busy,
    output logic           o_valid,
    output rlf_pkg::t_item o_item
);

    rlf_pkg::t_item r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    rlf_pkg::t_item w_item;
    logic           w_push;
    logic           w_pop;

    always_comb begin
        w_item.len  = i_record_length;
        w_item.data = i_data_byte;
        unique case (i_command)
            rlf_pkg::CMD_START: begin
                w_item.kind = (32'(i_record_length) > rlf_pkg::MAX_RECORD_BYTES)
                              ? rlf_pkg::K_BAD : rlf_pkg::K_START;
            end
            rlf_pkg::CMD_APPEND: w_item.kind = rlf_pkg::K_APPEND;
            rlf_pkg::CMD_READ:   w_item.kind = rlf_pkg::K_READ;
            default:             w_item.kind = rlf_pkg::K_BAD;
        endcase
    end

    assign o_busy  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_start && !o_busy;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

/* hdl/rlf_back.sv */
// Back end: executes queued items against the circular byte store.
// Depends on rlf_pkg; owns the store memory and the read limit register.
module rlf_back #(
    parameter int STORE_DEPTH = rlf_pkg::STORE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rlf_pkg::t_item i_item,
    output logic           o_pop,
    input  logic           i_cfg_we,
    input  logic [7:0]     i_cfg_wdata,
    output logic           o_done,
    output logic [7:0]     o_read_byte,
    output logic           o_byte_valid,
    output logic           o_last_of_record,
    output logic [1:0]     o_status,
    output logic [10:0]    o_record_count,
    output logic [10:0]    o_records_dropped
);

    localparam int PTR_W  = $clog2(STORE_DEPTH);
    localparam int FREE_W = $clog2(STORE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVICT,
        S_EV_WAIT,
        S_RD_HDR,
        S_RD_DATA
    } t_state;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] r_rdata;

    t_state            r_state,  n_state;
    logic [PTR_W-1:0]  r_head,   n_head;
    logic [PTR_W-1:0]  r_tail,   n_tail;
    logic [FREE_W-1:0] r_count,  n_count;
    logic [FREE_W-1:0] r_free,   n_free;
    logic [7:0]        r_left,   n_left;
    logic              r_open,   n_open;
    logic [7:0]        r_offset, n_offset;
    logic [7:0]        r_limit;
    logic [7:0]        r_len,    n_len;
    logic [7:0]        r_hlen,   n_hlen;
    logic [7:0]        r_n,      n_n;
    logic              r_trunc,  n_trunc;
    logic [10:0]       r_drop,   n_drop;

    logic              n_done, n_bvalid, n_last;
    logic [7:0]        n_rbyte;
    logic [1:0]        n_status;

    logic              w_we;
    logic [PTR_W-1:0]  w_waddr, w_raddr;
    logic [7:0]        w_wdata;
    logic [7:0]        w_hn;
    logic [7:0]        w_off1;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p, input logic [8:0] n);
        logic [PTR_W:0] s;
        s = {1'b0, p} + (PTR_W + 1)'(n);
        if (s >= (PTR_W + 1)'(STORE_DEPTH)) s = s - (PTR_W + 1)'(STORE_DEPTH);
        return s[PTR_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rdata <= mem[w_raddr];
    end

    assign w_hn   = (r_rdata < r_limit) ? r_rdata : r_limit;
    assign w_off1 = r_offset + 8'd1;

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_free   = r_free;
        n_left   = r_left;
        n_open   = r_open;
        n_offset = r_offset;
        n_len    = r_len;
        n_hlen   = r_hlen;
        n_n      = r_n;
        n_trunc  = r_trunc;
        n_drop   = r_drop;
        n_done   = 1'b0;
        n_bvalid = 1'b0;
        n_last   = 1'b0;
        n_rbyte  = 8'd0;
        n_status = rlf_pkg::ST_OK;
        o_pop    = 1'b0;
        w_we     = 1'b0;
        w_waddr  = r_tail;
        w_wdata  = i_item.data;
        w_raddr  = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop  = 1'b1;
                    n_drop = 11'd0;
                    unique case (i_item.kind)
                        rlf_pkg::K_START: begin
                            if (r_open) begin
                                n_done   = 1'b1;
                                n_status = rlf_pkg::ST_ERROR;
                            end else begin
                                n_len   = i_item.len;
                                n_state = S_EVICT;
                            end
                        end
                        rlf_pkg::K_APPEND: begin
                            n_done = 1'b1;
                            if (!r_open) begin
                                n_status = rlf_pkg::ST_ERROR;
                            end else begin
                                w_we   = 1'b1;
                                n_tail = adv(r_tail, 9'd1);
                                n_left = r_left - 8'd1;
                                if (r_left == 8'd1) begin
                                    n_open  = 1'b0;
                                    n_count = r_count + FREE_W'(1);
                                end
                            end
                        end
                        rlf_pkg::K_READ: begin
                            if (r_count == '0) begin
                                n_done   = 1'b1;
                                n_status = rlf_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_RD_HDR;
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = rlf_pkg::ST_ERROR;
                        end
                    endcase
                end
            end
            S_EVICT: begin
                // evict the head record through S_EV_WAIT until the record fits or the store is empty
                if (r_free < FREE_W'({1'b0, r_len} + 9'd1) && r_count != '0) begin
                    n_state = S_EV_WAIT;
                end else begin
                    w_we    = 1'b1;
                    w_wdata = r_len;
                    n_tail  = adv(r_tail, 9'd1);
                    n_free  = r_free - FREE_W'({1'b0, r_len} + 9'd1);
                    if (r_len == 8'd0) begin
                        n_count = r_count + FREE_W'(1);
                    end else begin
                        n_open = 1'b1;
                        n_left = r_len;
                    end
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EV_WAIT: begin
                n_head   = adv(r_head, {1'b0, r_rdata} + 9'd1);
                n_free   = r_free + FREE_W'({1'b0, r_rdata} + 9'd1);
                n_count  = r_count - FREE_W'(1);
                n_offset = 8'd0;
                n_drop   = r_drop + 11'd1;
                n_state  = S_EVICT;
            end
            S_RD_HDR: begin
                n_hlen  = r_rdata;
                n_n     = w_hn;
                n_trunc = r_rdata > r_limit;
                if (r_offset < w_hn) begin
                    w_raddr = adv(r_head, {1'b0, w_off1});
                    n_state = S_RD_DATA;
                end else begin
                    // limit already reached: drop the head with no byte
                    n_head   = adv(r_head, {1'b0, r_rdata} + 9'd1);
                    n_free   = r_free + FREE_W'({1'b0, r_rdata} + 9'd1);
                    n_count  = r_count - FREE_W'(1);
                    n_offset = 8'd0;
                    n_last   = 1'b1;
                    n_status = (r_rdata > r_limit) ? rlf_pkg::ST_TRUNC : rlf_pkg::ST_OK;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_RD_DATA: begin
                n_rbyte  = r_rdata;
                n_bvalid = 1'b1;
                n_offset = w_off1;
                n_done   = 1'b1;
                n_state  = S_IDLE;
                if (w_off1 >= r_n) begin
                    n_head   = adv(r_head, {1'b0, r_hlen} + 9'd1);
                    n_free   = r_free + FREE_W'({1'b0, r_hlen} + 9'd1);
                    n_count  = r_count - FREE_W'(1);
                    n_offset = 8'd0;
                    n_last   = 1'b1;
                    n_status = r_trunc ? rlf_pkg::ST_TRUNC : rlf_pkg::ST_OK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_free   <= FREE_W'(STORE_DEPTH);
            r_left   <= 8'd0;
            r_open   <= 1'b0;
            r_offset <= 8'd0;
            r_limit  <= rlf_pkg::READ_LIMIT_RESET;
            r_drop   <= 11'd0;
            o_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_free   <= n_free;
            r_left   <= n_left;
            r_open   <= n_open;
            r_offset <= n_offset;
            r_drop   <= n_drop;
            o_done   <= n_done;
            if (i_cfg_we) r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_hlen  <= n_hlen;
        r_n     <= n_n;
        r_trunc <= n_trunc;
        if (n_done) begin
            o_read_byte       <= n_rbyte;
            o_byte_valid      <= n_bvalid;
            o_last_of_record  <= n_last;
            o_status          <= n_status;
            o_record_count    <= 11'(n_count);
            o_records_dropped <= n_drop;
        end
    end

endmodule

/* hdl/length_prefixed_record_fifo.sv */
// Items reach the back end through a two-entry queue; the back end finishes an append, an error
// or an empty read straight from idle; a read goes through a header read and, unless the head is
// dropped with no byte, a data read; a start goes through an evict step, with one header read per
// evicted record. The back end takes a new item only once it is idle again, and the queue takes
// items meanwhile.
// Synchronous active-low reset empties the store and sets read_limit to 255.
module length_prefixed_record_fifo #(
    parameter int STORE_DEPTH = rlf_pkg::STORE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_record_length,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    output logic        o_done,
    output logic [7:0]  o_read_byte,
    output logic        o_byte_valid,
    output logic        o_last_of_record,
    output logic [1:0]  o_status,
    output logic [10:0] o_record_count,
    output logic [10:0] o_records_dropped
);

    logic           w_valid;
    logic           w_pop;
    rlf_pkg::t_item w_item;

    rlf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_command       (i_command),
        .i_record_length (i_record_length),
        .i_data_byte     (i_data_byte),
        .i_pop           (w_pop),
        .o_busy          (o_busy),
        .o_valid         (w_valid),
        .o_item          (w_item)
    );

    rlf_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_valid),
        .i_item            (w_item),
        .o_pop             (w_pop),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_done            (o_done),
        .o_read_byte       (o_read_byte),
        .o_byte_valid      (o_byte_valid),
        .o_last_of_record  (o_last_of_record),
        .o_status          (o_status),
        .o_record_count    (o_record_count),
        .o_records_dropped (o_records_dropped)
    );

endmodule

/* hdl/rlf_checker.sv */
// Port-level checks for length_prefixed_record_fifo, bound to the top level.
// Depends on rlf_pkg and length_prefixed_record_fifo_macros.svh.
`include "length_prefixed_record_fifo_macros.svh"

module rlf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_busy,
    input logic        o_done,
    input logic        o_byte_valid,
    input logic        o_last_of_record,
    input logic [1:0]  o_status,
    input logic [10:0] o_record_count,
    input logic [10:0] o_records_dropped
);

    `RLF_ASSERT_RST(a_reset_quiet, !i_rst_n |=> !o_done && !o_busy)
    `RLF_ASSERT(a_byte_status, o_done && o_byte_valid |-> o_status == rlf_pkg::ST_OK || o_status == rlf_pkg::ST_TRUNC)
    `RLF_ASSERT(a_empty_read, o_done && o_status == rlf_pkg::ST_EMPTY |-> !o_byte_valid && !o_last_of_record && o_record_count == 11'd0)
    `RLF_ASSERT(a_evict_start, o_done && o_records_dropped != 11'd0 |-> !o_byte_valid && !o_last_of_record)
    `RLF_ASSERT(a_error_quiet, o_done && o_status == rlf_pkg::ST_ERROR |-> o_records_dropped == 11'd0 && !o_byte_valid)

endmodule

bind length_prefixed_record_fifo rlf_checker u_rlf_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_busy            (o_busy),
    .o_done            (o_done),
    .o_byte_valid      (o_byte_valid),
    .o_last_of_record  (o_last_of_record),
    .o_status          (o_status),
    .o_record_count    (o_record_count),
    .o_records_dropped (o_records_dropped)
);

/* tb/testbench.sv */
// Testbench for length_prefixed_record_fifo: random and directed commands,
// results checked against an in-bench model of the record store. Needs rlf_pkg.
`timescale 1ns / 100ps

module testbench;

    localparam int DEPTH = rlf_pkg::STORE_DEPTH_DEF;
    // command code with no meaning, rejected by the block
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [7:0]  rbyte;
        logic        valid;
        logic        last;
        logic [1:0]  status;
        logic [10:0] count;
        logic [10:0] dropped;
    } t_outcome;

    class record_scoreboard;
        logic [7:0] mem [DEPTH];
        int unsigned head, tail, nrec, free_b, left, roff, limit;
        bit open;
        t_outcome pending[$];
        int errors;

        function void reset_state();
            head = 0; tail = 0; nrec = 0; free_b = DEPTH; left = 0;
            roff = 0; limit = 255; open = 0; errors = 0;
            pending.delete();
        endfunction

        function int unsigned wrap(int unsigned p, int unsigned n);
            return (p + n) % DEPTH;
        endfunction

        function void evict_head();
            int unsigned l;
            l = mem[head];
            head = wrap(head, l + 1);
            free_b += l + 1;
            if (nrec > 0) nrec--;
            roff = 0;
        endfunction

        function void push_byte(logic [7:0] b);
            mem[tail] = b;
            tail = wrap(tail, 1);
        endfunction

        // note an accepted item and queue what it should produce
        function void note_item(logic [1:0] cmd, logic [7:0] len, logic [7:0] data);
            t_outcome o;
            int unsigned hlen, n;
            bit trunc;
            o = '{default: 0};
            o.status = rlf_pkg::ST_OK;
            if (cmd == rlf_pkg::CMD_START) begin
                if (open || len > rlf_pkg::MAX_RECORD_BYTES) begin
                    o.status = rlf_pkg::ST_ERROR;
                end else begin
                    while (free_b < len + 1 && nrec > 0) begin
                        evict_head();
                        o.dropped++;
                    end
                    push_byte(len);
                    free_b -= len + 1;
                    if (len == 0) nrec++;
                    else begin
                        open = 1;
                        left = len;
                    end
                end
            end else if (cmd == rlf_pkg::CMD_APPEND) begin
                if (!open) o.status = rlf_pkg::ST_ERROR;
                else begin
                    push_byte(data);
                    left--;
                    if (left == 0) begin
                        open = 0;
                        nrec++;
                    end
                end
            end else if (cmd == rlf_pkg::CMD_READ) begin
                if (nrec == 0) o.status = rlf_pkg::ST_EMPTY;
                else begin
                    hlen = mem[head];
                    n = (hlen < limit) ? hlen : limit;
                    trunc = hlen > limit;
                    if (roff < n) begin
                        o.rbyte = mem[wrap(head, roff + 1)];
                        o.valid = 1;
                        roff++;
                    end
                    if (roff >= n) begin
                        evict_head();
                        o.last = 1;
                        if (trunc) o.status = rlf_pkg::ST_TRUNC;
                    end
                end
            end else begin
                o.status = rlf_pkg::ST_ERROR;
            end
            o.count = nrec;
            pending.push_back(o);
        endfunction

        function void check_result(t_outcome a);
            t_outcome e;
            if (pending.size() == 0) begin
                $error("unexpected result");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.rbyte !== e.rbyte) begin
                $error("read_byte exp %0d got %0d", e.rbyte, a.rbyte); errors++;
            end
            if (a.valid !== e.valid) begin
                $error("byte_valid exp %0d got %0d", e.valid, a.valid); errors++;
            end
            if (a.last !== e.last) begin
                $error("last_of_record exp %0d got %0d", e.last, a.last); errors++;
            end
            if (a.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, a.status); errors++;
            end
            if (a.count !== e.count) begin
                $error("record_count exp %0d got %0d", e.count, a.count); errors++;
            end
            if (a.dropped !== e.dropped) begin
                $error("records_dropped exp %0d got %0d", e.dropped, a.dropped);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_start = 0;
    logic [1:0]  i_command = rlf_pkg::CMD_READ;
    logic [7:0]  i_record_length = 0;
    logic [7:0]  i_data_byte = 0;
    logic        i_cfg_we = 0;
    logic [7:0]  i_cfg_wdata = 0;
    logic        o_busy, o_done, o_byte_valid, o_last_of_record;
    logic [7:0]  o_read_byte;
    logic [1:0]  o_status;
    logic [10:0] o_record_count, o_records_dropped;

    record_scoreboard sb;

    length_prefixed_record_fifo u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_command(i_command), .i_record_length(i_record_length),
        .i_data_byte(i_data_byte), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_done(o_done), .o_read_byte(o_read_byte), .o_byte_valid(o_byte_valid),
        .o_last_of_record(o_last_of_record), .o_status(o_status),
        .o_record_count(o_record_count), .o_records_dropped(o_records_dropped)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        t_outcome r;
        if (i_rst_n && o_done) begin
            r.rbyte = o_read_byte; r.valid = o_byte_valid; r.last = o_last_of_record;
            r.status = o_status; r.count = o_record_count;
            r.dropped = o_records_dropped;
            sb.check_result(r);
        end
    end

    int gap_left = 0;
    int burst_left = 0;

    // present one item, holding start until the edge that takes it;
    // start drops only for a gap or a drain, so back-to-back items keep it high
    task automatic send_item(logic [1:0] cmd, logic [7:0] len, logic [7:0] data);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
        if (gap_left != 0) begin
            i_start <= 0;
            repeat (gap_left) @(posedge i_clk);
        end
        gap_left = 0;
        burst_left--;
        i_start <= 1;
        i_command <= cmd;
        i_record_length <= len;
        i_data_byte <= data;
        do @(posedge i_clk); while (o_busy);
        sb.note_item(cmd, len, data);
    endtask

    task automatic drain();
        i_start <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [7:0] v);
        drain();
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.limit = v;
    endtask

    task automatic send_record(int len);
        send_item(rlf_pkg::CMD_START, len, $urandom);
        for (int k = 0; k < len; k++) send_item(rlf_pkg::CMD_APPEND, $urandom, $urandom);
    endtask

    int sent;

    initial begin
        int len, c;
        sb = new();
        sb.reset_state();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty read, stray append, bad command, zero-length record
        send_item(rlf_pkg::CMD_READ, 0, 0);
        send_item(rlf_pkg::CMD_APPEND, 8'hFF, 8'hFF);
        send_item(CMD_UNUSED, 8'hFF, 8'hAA);
        send_item(rlf_pkg::CMD_START, 0, 0);
        send_item(rlf_pkg::CMD_READ, 0, 0);
        send_item(rlf_pkg::CMD_START, 2, 0);
        send_item(rlf_pkg::CMD_START, 1, 0);       // start while open
        send_item(rlf_pkg::CMD_APPEND, 8'h00, 8'h55);
        send_item(rlf_pkg::CMD_APPEND, 8'hFF, 8'hAA);
        send_item(rlf_pkg::CMD_READ, 0, 0);
        send_item(rlf_pkg::CMD_READ, 0, 0);
        send_record(255);
        write_limit(8'd0);
        send_item(rlf_pkg::CMD_READ, 0, 0);        // limit zero drops the record
        write_limit(8'd3);
        send_record(5);
        for (int k = 0; k < 4; k++) send_item(rlf_pkg::CMD_READ, 0, 0);
        drain();                                   // sender waits for every result

        write_limit(8'd255);
        // random: mostly well-formed records, with reads and noise
        sent = 0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                1: write_limit($urandom_range(1, 20));
                2: write_limit(8'd255);
                3: write_limit($urandom_range(0, 255));
                default: ;
            endcase
            while (sent < 475 * (phase + 1)) begin
                c = $urandom_range(0, 99);
                if (c < 45) begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 255)
                                                       : $urandom_range(0, 12);
                    if ($urandom_range(0, 19) == 0) begin
                        send_item(rlf_pkg::CMD_START, len, $urandom);
                        sent++;
                    end else begin
                        send_record(len);
                        sent += len + 1;
                    end
                    // reads may stop partway into the head record, so later starts can evict it
                end else if (c < 95) begin
                    send_item(rlf_pkg::CMD_READ, $urandom, $urandom);
                    sent++;
                end else begin
                    send_item($urandom_range(0, 3), $urandom, $urandom);
                    sent++;
                end
            end
        end
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
